FILE: sv/rwhp_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
// No dependencies; imported by riff_wave_header_parser.
package rwhp_pkg;

  localparam int unsigned DEF_COUNT_BITS = 32;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 152;   // 145 field bits, zero filled to whole bytes
  localparam int unsigned OUT_USER_W = 3;

  // Four-character codes, first character in the lowest byte
  localparam logic [31:0] RIFF_MAGIC = 32'h4646_4952;  // "RIFF"
  localparam logic [31:0] WAVE_MAGIC = 32'h4556_4157;  // "WAVE"
  localparam logic [31:0] TAG_FMT    = 32'h2074_6D66;  // "fmt "
  localparam logic [31:0] TAG_DATA   = 32'h6174_6164;  // "data"

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [3:0]  HEAD_LAST   = 4'd11;        // last byte of the RIFF/WAVE header

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_CHDR,
    PH_BODY,
    PH_PAD,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_FMT,
    KIND_DATA,
    KIND_SHORT
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_HEADER,
    ST_OVERRUN,
    ST_FMT_SHORT,
    ST_MISSING,
    ST_TOO_LONG
  } status_t;

endpackage

FILE: sv/riff_wave_header_parser.sv
// RIFF/WAVE header parser: walks a byte stream of a WAV file and reports
// the format and data chunk summary on the last byte. Depends on rwhp_pkg.
//
// channel   dir  content
// s_*       in   one file byte per transaction, tlast on the final byte
// m_*       out  one summary per file, status in tuser
//
// Each byte is parsed by the logic between the state registers and the result
// register, so a byte can be taken in every cycle while s_tready is high.
// A result sits in the output register, with one skid entry behind it; s_tready
// drops only while both are full. Reset is synchronous and clears all control
// state; the parser also returns to its reset state after each tlast byte.
module riff_wave_header_parser #(
  parameter int unsigned COUNT_BITS = rwhp_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rwhp_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] byte_value
  input  logic                             s_tlast,   // last_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [15:0] audio_format, [31:16] channel_count, [63:32] sample_rate,
  // [79:64] sample_bits, [111:80] payload_offset, [143:112] payload_bytes,
  // [144] pcm16_stereo_ok, rest zero
  output logic [rwhp_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [rwhp_pkg::OUT_USER_W-1:0]  m_tuser    // [2:0] status
);
  import rwhp_pkg::*;

  localparam int unsigned OFS_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam logic [COUNT_BITS-1:0] POS_MAX = '1;

  // control state
  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] pos, pos_next;
  logic [2:0]            hdr_idx, hdr_idx_next;
  logic [31:0]           remaining, remaining_next;
  kind_t                 kind, kind_next;
  logic                  seen_fmt, seen_fmt_next;
  logic                  seen_data, seen_data_next;
  logic [4:0]            fmt_pos, fmt_pos_next;
  logic [2:0]            err, err_next;

  // payload state
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_len, chunk_len_next;
  logic [15:0] audio_format, audio_format_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] sample_rate, sample_rate_next;
  logic [15:0] sample_bits, sample_bits_next;
  logic [31:0] payload_offset, payload_offset_next;
  logic [31:0] payload_bytes, payload_bytes_next;

  // output register and skid entry
  logic                  out_valid, skid_valid;
  logic [OUT_DATA_W-1:0] out_data, skid_data;
  logic [OUT_USER_W-1:0] out_user, skid_user;

  logic                  accept;
  logic                  res_valid;
  status_t               res_status;
  logic [OUT_DATA_W-1:0] res_data;
  logic                  pcm_ok;
  logic [7:0]            b;
  logic [COUNT_BITS-1:0] pos_inc;
  logic [OFS_W-1:0]      pos_ext;

  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign res_valid = accept && s_tlast;
  assign b         = s_tdata;
  assign pos_inc   = pos + 1'b1;
  assign pos_ext   = OFS_W'(pos_inc);

  // next-state logic for one byte
  always_comb begin
    logic [31:0] tag_asm;
    logic [31:0] len_asm;
    kind_t       kind_new;

    phase_next          = phase;
    pos_next            = pos;
    hdr_idx_next        = hdr_idx;
    remaining_next      = remaining;
    kind_next           = kind;
    seen_fmt_next       = seen_fmt;
    seen_data_next      = seen_data;
    fmt_pos_next        = fmt_pos;
    err_next            = err;
    chunk_tag_next      = chunk_tag;
    chunk_len_next      = chunk_len;
    audio_format_next   = audio_format;
    channel_count_next  = channel_count;
    sample_rate_next    = sample_rate;
    sample_bits_next    = sample_bits;
    payload_offset_next = payload_offset;
    payload_bytes_next  = payload_bytes;

    tag_asm  = chunk_tag;
    len_asm  = chunk_len;
    kind_new = KIND_OTHER;

    if (pos == POS_MAX) begin
      // position counter full: too long wins over any earlier error
      err_next   = ST_TOO_LONG;
      phase_next = PH_HALT;
    end else begin
      pos_next = pos_inc;
      unique case (phase)
        PH_HEAD: begin
          if (pos < COUNT_BITS'(4) && b != RIFF_MAGIC[{pos[1:0], 3'b000} +: 8]) begin
            if (err == ST_OK) err_next = ST_BAD_HEADER;
            phase_next = PH_HALT;
          end else if (pos >= COUNT_BITS'(8) && pos <= COUNT_BITS'(HEAD_LAST) &&
                       b != WAVE_MAGIC[{pos[1:0], 3'b000} +: 8]) begin
            if (err == ST_OK) err_next = ST_BAD_HEADER;
            phase_next = PH_HALT;
          end else if (pos == COUNT_BITS'(HEAD_LAST)) begin
            phase_next   = PH_CHDR;
            hdr_idx_next = '0;
          end
        end
        PH_CHDR: begin
          if (!hdr_idx[2]) tag_asm[{hdr_idx[1:0], 3'b000} +: 8] = b;
          else             len_asm[{hdr_idx[1:0], 3'b000} +: 8] = b;
          chunk_tag_next = tag_asm;
          chunk_len_next = len_asm;
          hdr_idx_next   = hdr_idx + 1'b1;
          if (hdr_idx == 3'd7) begin
            if (!seen_fmt && tag_asm == TAG_FMT) begin
              if (len_asm < FMT_MIN_LEN) begin
                kind_new = KIND_SHORT;
              end else begin
                kind_new      = KIND_FMT;
                seen_fmt_next = 1'b1;
              end
            end else if (!seen_data && tag_asm == TAG_DATA) begin
              kind_new            = KIND_DATA;
              seen_data_next      = 1'b1;
              payload_offset_next = pos_ext[31:0];
              payload_bytes_next  = len_asm;
            end
            kind_next      = kind_new;
            remaining_next = len_asm;
            fmt_pos_next   = '0;
            if (len_asm == '0) begin
              if (kind_new == KIND_SHORT) begin
                if (err == ST_OK) err_next = ST_FMT_SHORT;
                phase_next = PH_HALT;
              end else begin
                phase_next   = len_asm[0] ? PH_PAD : PH_CHDR;
                hdr_idx_next = '0;
              end
            end else begin
              phase_next = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (kind == KIND_FMT) begin
            case (fmt_pos)
              5'd0, 5'd1:             audio_format_next[{fmt_pos[0], 3'b000} +: 8] = b;
              5'd2, 5'd3:             channel_count_next[{fmt_pos[0], 3'b000} +: 8] = b;
              5'd4, 5'd5, 5'd6, 5'd7: sample_rate_next[{fmt_pos[1:0], 3'b000} +: 8] = b;
              5'd14, 5'd15:           sample_bits_next[{fmt_pos[0], 3'b000} +: 8] = b;
              default: ;
            endcase
          end
          if (!fmt_pos[4]) fmt_pos_next = fmt_pos + 1'b1;
          remaining_next = remaining - 1'b1;
          if (remaining == 32'd1) begin
            if (kind == KIND_SHORT) begin
              if (err == ST_OK) err_next = ST_FMT_SHORT;
              phase_next = PH_HALT;
            end else begin
              phase_next   = chunk_len[0] ? PH_PAD : PH_CHDR;
              hdr_idx_next = '0;
            end
          end
        end
        PH_PAD: begin
          phase_next   = PH_CHDR;
          hdr_idx_next = '0;
        end
        PH_HALT: ;
        default: ;
      endcase
    end
  end

  // summary from the state after this byte
  always_comb begin
    res_status = status_t'(err_next);
    if (err_next == ST_OK) begin
      if (phase_next == PH_HEAD)             res_status = ST_BAD_HEADER;
      else if (phase_next == PH_BODY)        res_status = ST_OVERRUN;
      else if (!seen_fmt_next || !seen_data_next) res_status = ST_MISSING;
    end
    pcm_ok = (audio_format_next == 16'd1) && (sample_bits_next == 16'd16) &&
             (channel_count_next == 16'd2) && (sample_rate_next != '0) &&
             (payload_bytes_next != '0) && (payload_bytes_next[1:0] == 2'b00);
    res_data = '0;
    if (res_status == ST_OK) begin
      res_data[15:0]    = audio_format_next;
      res_data[31:16]   = channel_count_next;
      res_data[63:32]   = sample_rate_next;
      res_data[79:64]   = sample_bits_next;
      res_data[111:80]  = payload_offset_next;
      res_data[143:112] = payload_bytes_next;
      res_data[144]     = pcm_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      phase     <= PH_HEAD;
      pos       <= '0;
      hdr_idx   <= '0;
      remaining <= '0;
      kind      <= KIND_OTHER;
      seen_fmt  <= 1'b0;
      seen_data <= 1'b0;
      fmt_pos   <= '0;
      err       <= ST_OK;
    end else if (accept) begin
      phase     <= phase_next;
      pos       <= pos_next;
      hdr_idx   <= hdr_idx_next;
      remaining <= remaining_next;
      kind      <= kind_next;
      seen_fmt  <= seen_fmt_next;
      seen_data <= seen_data_next;
      fmt_pos   <= fmt_pos_next;
      err       <= err_next;
    end
  end

  // captured fields are overwritten before use in each file
  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      chunk_tag <= '0;
      chunk_len <= '0;
    end else if (accept) begin
      chunk_tag <= chunk_tag_next;
      chunk_len <= chunk_len_next;
    end
    if (accept) begin
      audio_format   <= res_valid ? '0 : audio_format_next;
      channel_count  <= res_valid ? '0 : channel_count_next;
      sample_rate    <= res_valid ? '0 : sample_rate_next;
      sample_bits    <= res_valid ? '0 : sample_bits_next;
      payload_offset <= payload_offset_next;
      payload_bytes  <= payload_bytes_next;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      if (!out_valid) out_valid  <= 1'b1;
      else            skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
        out_user <= skid_user;
      end else begin
        out_data <= res_data;
        out_user <= res_status;
      end
    end else if (res_valid) begin
      if (!out_valid) begin
        out_data <= res_data;
        out_user <= res_status;
      end else begin
        skid_data <= res_data;
        skid_user <= res_status;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

endmodule
